// ===== hdl/ssm_pkg.sv =====
// package for the substring search matcher: sizes, request codes and the
// command word passed from the front end through the queue to the matcher
// no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int PATTERN_MAX  = 32;
    localparam int BUFFER_DEPTH = 1024;
    localparam int FIFO_DEPTH   = 4;

    localparam int PAT_IDX_W  = $clog2(PATTERN_MAX);
    localparam int PAT_LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W      = $clog2(BUFFER_DEPTH + 1);
    localparam int POS_W      = 10;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [PAT_LEN_W-1:0]  PAT_LIMIT   = PAT_LEN_W'(PATTERN_MAX);
    localparam logic [IDX_W-1:0]      DEPTH_LIMIT = IDX_W'(BUFFER_DEPTH);
    localparam logic [FIFO_CNT_W-1:0] FIFO_FULL   = FIFO_CNT_W'(FIFO_DEPTH);

    typedef enum logic {
        REQ_PATTERN = 1'b0,
        REQ_DATA    = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind  kind;
        logic       start;
        logic [7:0] value;
        logic       last;
    } t_cmd;

endpackage

// ===== hdl/ssm_front.sv =====
// front end: accepts requests, tracks pattern loading and tags each
// request that opens a new pattern before pushing it to the queue
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_req_type,
    input  logic [7:0]    i_data_byte,
    input  logic          i_is_last,
    input  logic          i_q_full,
    output logic          o_push,
    output ssm_pkg::t_cmd o_cmd
);

    logic                r_loading;
    logic                n_loading;
    ssm_pkg::t_req_kind  w_kind;

    assign w_kind     = ssm_pkg::t_req_kind'(i_req_type);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.kind  = w_kind;
        o_cmd.start = (w_kind == ssm_pkg::REQ_PATTERN) && !r_loading;
        o_cmd.value = i_data_byte;
        o_cmd.last  = i_is_last;
    end

    always_comb begin
        n_loading = r_loading;
        if (o_push) begin
            unique case (w_kind)
                ssm_pkg::REQ_PATTERN: n_loading = !i_is_last;
                ssm_pkg::REQ_DATA:    n_loading = 1'b0;
                default:              n_loading = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading <= 1'b0;
        end else begin
            r_loading <= n_loading;
        end
    end

endmodule

// ===== hdl/ssm_fifo.sv =====
// short request queue between the front end and the matcher
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ssm_pkg::t_cmd o_cmd
);

    ssm_pkg::t_cmd                      r_mem [ssm_pkg::FIFO_DEPTH];
    logic [ssm_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [ssm_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [ssm_pkg::FIFO_CNT_W-1:0]     r_count;
    logic [ssm_pkg::FIFO_CNT_W-1:0]     n_count;

    assign o_full  = (r_count == ssm_pkg::FIFO_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        priority if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ssm_pkg::FIFO_FULL)
        else $error("queue count beyond depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count != '0)
        else $error("pushed request lost");
`endif

endmodule

// ===== hdl/ssm_back.sv =====
// matcher: pattern store, parallel byte compare, partial-match vector,
// first-occurrence capture and the result register
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  ssm_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [ssm_pkg::POS_W-1:0] o_match_start
);

    logic [7:0]                       r_store [ssm_pkg::PATTERN_MAX];
    logic [ssm_pkg::PAT_LEN_W-1:0]    r_len;
    logic [ssm_pkg::PATTERN_MAX-1:0]  r_pm;
    logic [ssm_pkg::IDX_W-1:0]        r_idx;
    logic                             r_seen;
    logic [ssm_pkg::POS_W-1:0]        r_pos;
    logic                             r_out_valid;
    logic                             r_found;
    logic [ssm_pkg::POS_W-1:0]        r_start;

    logic [ssm_pkg::PAT_LEN_W-1:0]    n_len;
    logic [ssm_pkg::PATTERN_MAX-1:0]  n_pm;
    logic [ssm_pkg::IDX_W-1:0]        n_idx;
    logic                             n_seen;
    logic [ssm_pkg::POS_W-1:0]        n_pos;
    logic                             n_out_valid;
    logic                             n_found;
    logic [ssm_pkg::POS_W-1:0]        n_start;

    logic [ssm_pkg::PATTERN_MAX-1:0]  w_eq;
    logic [ssm_pkg::PAT_LEN_W-1:0]    w_len_eff;
    logic [ssm_pkg::PAT_LEN_W-1:0]    w_len_m1;
    logic                             w_wr;
    logic [ssm_pkg::PAT_IDX_W-1:0]    w_wr_addr;

    assign o_pop         = i_cmd_valid && !(r_out_valid && i_out_stall);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_start = r_start;

    // byte compare against every stored pattern byte
    always_comb begin
        for (int k = 0; k < ssm_pkg::PATTERN_MAX; k++) begin
            w_eq[k] = (r_store[k] == i_cmd.value) &&
                      (ssm_pkg::PAT_LEN_W'(k) < r_len);
        end
    end

    assign w_len_m1 = r_len - 1'b1;

    always_comb begin
        n_len       = r_len;
        n_pm        = r_pm;
        n_idx       = r_idx;
        n_seen      = r_seen;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_found     = r_found;
        n_start     = r_start;
        w_len_eff   = i_cmd.start ? '0 : r_len;
        w_wr        = 1'b0;
        w_wr_addr   = w_len_eff[ssm_pkg::PAT_IDX_W-1:0];
        if (o_pop) begin
            unique case (i_cmd.kind)
                ssm_pkg::REQ_PATTERN: begin
                    if (i_cmd.start) begin
                        n_pm   = '0;
                        n_idx  = '0;
                        n_seen = 1'b0;
                        n_pos  = '0;
                    end
                    n_len = w_len_eff;
                    if (w_len_eff < ssm_pkg::PAT_LIMIT) begin
                        w_wr  = 1'b1;
                        n_len = w_len_eff + 1'b1;
                    end
                end
                ssm_pkg::REQ_DATA: begin
                    if (r_idx < ssm_pkg::DEPTH_LIMIT) begin
                        if (r_len != '0) begin
                            n_pm = {r_pm[ssm_pkg::PATTERN_MAX-2:0], 1'b1} & w_eq;
                            if (!r_seen && n_pm[w_len_m1[ssm_pkg::PAT_IDX_W-1:0]]) begin
                                n_seen = 1'b1;
                                n_pos  = r_idx[ssm_pkg::POS_W-1:0] -
                                         {{(ssm_pkg::POS_W - ssm_pkg::PAT_LEN_W){1'b0}},
                                          w_len_m1};
                            end
                        end
                        n_idx = r_idx + 1'b1;
                    end
                    if (i_cmd.last) begin
                        n_out_valid = 1'b1;
                        n_found     = n_seen;
                        n_start     = n_seen ? n_pos : '0;
                        n_pm        = '0;
                        n_idx       = '0;
                        n_seen      = 1'b0;
                        n_pos       = '0;
                    end
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[w_wr_addr] <= i_cmd.value;
        end
        r_found <= n_found;
        r_start <= n_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pm        <= '0;
            r_idx       <= '0;
            r_seen      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_pm        <= n_pm;
            r_idx       <= n_idx;
            r_seen      <= n_seen;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= ssm_pkg::PAT_LIMIT)
        else $error("pattern length beyond store");

    a_pm_in_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pm >> r_len) == '0)
        else $error("partial match beyond pattern length");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> r_start == '0)
        else $error("match start set without a match");
`endif

endmodule

// ===== hdl/substring_search_matcher_core.sv =====
// top level of the substring search matcher: front end, request queue and
// matcher
// depends on ssm_pkg, ssm_front, ssm_fifo, ssm_back
`timescale 1ns / 1ps

// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------
// request  | i_in_valid, o_in_stall  | i_req_type, i_data_byte, i_is_last
// result   | o_out_valid, i_out_stall| o_found, o_match_start
//
// one request per cycle sustained unless o_in_stall or i_out_stall holds it;
// the matcher's byte compare and match-vector shift are registered in r_pm
// a request is written into the queue at acceptance; with the queue ahead
// of it empty the matcher pops it; a last data byte loads the result register
// synchronous active-low reset clears queue, lengths and match state
// o_in_stall rises only when the four-entry queue is full; the matcher
// waits only while a result is held by i_out_stall

module substring_search_matcher_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_is_last,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [ssm_pkg::POS_W-1:0] o_match_start
);

    ssm_pkg::t_cmd w_push_cmd;
    ssm_pkg::t_cmd w_pop_cmd;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;

    ssm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    ssm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    ssm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .i_cmd         (w_pop_cmd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_match_start (o_match_start)
    );

endmodule
